/* sv/slt_pkg.sv */
package slt_pkg;

  // default table depth
  localparam int DEPTH_DEF = 16;

  // field widths
  localparam int VAL_W  = 32;
  localparam int POS_W  = 8;
  localparam int CMD_W  = 3;
  localparam int OCC_W  = 5;
  localparam int STAT_W = 2;

  // stream payload widths
  localparam int IN_DATA_W  = VAL_W + POS_W;
  localparam int OUT_DATA_W = VAL_W + 1 + STAT_W + OCC_W;

  // value returned by a get that misses
  localparam logic [VAL_W-1:0] MISS_VALUE = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT   = 3'd0,
    CMD_CONTAINS = 3'd1,
    CMD_GET      = 3'd2,
    CMD_REMOVE   = 3'd3,
    CMD_REVERSE  = 3'd4
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY
  } state_t;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic signed [VAL_W-1:0] val;
    logic [POS_W-1:0]        pos;
    logic                    load_tag;
    logic                    swap_en;
    logic                    parity;
    logic                    ins_en;
    logic                    rm_en;
  } cell_ctrl_t;

endpackage

/* sv/slt_cell.sv */
module slt_cell #(
  parameter int DEPTH = slt_pkg::DEPTH_DEF,
  parameter int IDX   = 0
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  slt_pkg::cell_ctrl_t               ctl,
  // left neighbor (toward the head)
  input  logic signed [slt_pkg::VAL_W-1:0]  lft_entry,
  input  logic                              lft_valid,
  input  logic [$clog2(DEPTH)-1:0]          lft_tag,
  input  logic                              lft_pre,
  // right neighbor (toward the tail)
  input  logic signed [slt_pkg::VAL_W-1:0]  rgt_entry,
  input  logic                              rgt_valid,
  input  logic [$clog2(DEPTH)-1:0]          rgt_tag,
  input  logic signed [slt_pkg::VAL_W-1:0]  rgt_get,
  input  logic                              rgt_hit,
  // own state and chain outputs
  output logic signed [slt_pkg::VAL_W-1:0]  entry_o,
  output logic                              valid_o,
  output logic [$clog2(DEPTH)-1:0]          tag_o,
  output logic                              pre_o,
  output logic signed [slt_pkg::VAL_W-1:0]  get_o,
  output logic                              hit_o
);
  import slt_pkg::*;

  localparam int TW = $clog2(DEPTH);
  localparam logic [POS_W-1:0] IDX_POS = POS_W'(IDX);
  localparam logic [TW-1:0]    IDX_TAG = TW'(IDX);
  localparam logic             IDX_PAR = 1'(IDX % 2);

  logic signed [VAL_W-1:0] entry_r, entry_nxt;
  logic                    valid_r, valid_nxt;
  logic [TW-1:0]           tag_r, tag_nxt;
  logic                    pre_r, pre_nxt;
  logic signed [VAL_W-1:0] get_r, get_nxt;
  logic                    hit_r, hit_nxt;

  logic fit;
  logic pair_right;
  logic swap_right;
  logic swap_left;

  // slot candidate: empty, or stored entry not less than the value
  assign fit = !valid_r || !($signed(entry_r) < $signed(ctl.val));

  // odd-even transposition pairing for the reverse pass
  assign pair_right = (IDX_PAR == ctl.parity);
  assign swap_right = pair_right && valid_r && rgt_valid && (tag_r < rgt_tag);
  assign swap_left  = !pair_right && valid_r && lft_valid && (lft_tag < tag_r);

  // update stored entry
  always_comb begin
    entry_nxt = entry_r;
    valid_nxt = valid_r;
    tag_nxt   = tag_r;
    if (ctl.load_tag) begin
      tag_nxt = IDX_TAG;
    end
    if (ctl.swap_en) begin
      if (swap_right) begin
        entry_nxt = rgt_entry;
        tag_nxt   = rgt_tag;
      end else if (swap_left) begin
        entry_nxt = lft_entry;
        tag_nxt   = lft_tag;
      end
    end
    if (ctl.ins_en) begin
      if (pre_r) begin
        entry_nxt = lft_entry;
        valid_nxt = lft_valid;
      end else if (fit) begin
        entry_nxt = ctl.val;
        valid_nxt = 1'b1;
      end
    end
    if (ctl.rm_en && (IDX_POS >= ctl.pos)) begin
      entry_nxt = rgt_entry;
      valid_nxt = rgt_valid;
    end
  end

  // advance the search chains one cell per cycle
  always_comb begin
    pre_nxt = lft_pre;
    get_nxt = (IDX_POS == ctl.pos) ? entry_r : rgt_get;
    hit_nxt = (valid_r && (entry_r == ctl.val)) || rgt_hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    tag_r   <= tag_nxt;
    pre_r   <= pre_nxt;
    get_r   <= get_nxt;
    hit_r   <= hit_nxt;
  end

  assign entry_o = entry_r;
  assign valid_o = valid_r;
  assign tag_o   = tag_r;
  assign pre_o   = pre_r | fit;
  assign get_o   = get_r;
  assign hit_o   = hit_r;

endmodule

/* sv/sorted_list_table_top.sv */
// Ordered table of up to DEPTH signed 32-bit values held in a row of cells,
// head first. Commands (in_tuser): insert before the first entry not less
// than the value, contains, get by position, remove by position, reverse.
// Every command runs a scan of the cell chain and then an apply step that
// loads its result into the output register; the next command is taken
// once the sequencer is back in idle, so no new command enters before the
// previous one is applied. The scan length is set by the cell chain: search
// results move one cell per cycle toward the head, the insert slot flag
// moves one cell per cycle toward the tail, and reverse runs DEPTH rounds of
// neighbor swaps. A waiting result does not block the next input transfer,
// but a result still unread when the next scan ends holds that command in
// its apply step until the output register frees. An insert into a full table
// is dropped with status full; remove beyond the stored count reports status
// range; get beyond it returns -1 with hit clear.
module sorted_list_table_top #(
  parameter int DEPTH = slt_pkg::DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // item_value [31:0], position [39:32]
  input  logic [slt_pkg::IN_DATA_W-1:0]      in_tdata,
  // cmd [2:0]
  input  logic [slt_pkg::CMD_W-1:0]          in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // read_value [31:0], hit [32], status [34:33], occupancy [39:35]
  output logic [slt_pkg::OUT_DATA_W-1:0]     out_tdata
);
  import slt_pkg::*;

  localparam int TW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  state_t                  state_r, state_nxt;
  logic [TW-1:0]           cnt_r, cnt_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic [CMD_W-1:0]        cmd_r;
  logic signed [VAL_W-1:0] val_r;
  logic [POS_W-1:0]        pos_r;
  logic                    out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0]   out_data_r;

  cell_ctrl_t              ctl;
  logic                    accept;
  logic                    last_scan;
  logic                    apply_go;
  logic                    full;
  logic                    in_range;

  logic signed [VAL_W-1:0] rd_value;
  logic                    rd_hit;
  status_t                 rd_status;

  // cell outputs
  logic signed [VAL_W-1:0] ent_w [DEPTH];
  logic                    vld_w [DEPTH];
  logic [TW-1:0]           tag_w [DEPTH];
  logic                    pre_w [DEPTH];
  logic signed [VAL_W-1:0] get_w [DEPTH];
  logic                    hit_w [DEPTH];
  logic [DEPTH-1:0]        vld_vec;

  assign accept    = in_tvalid && in_tready;
  assign last_scan = (cnt_r == TW'(DEPTH - 1));
  assign apply_go  = (state_r == ST_APPLY) && (!out_valid_r || out_tready);
  assign full      = (count_r == CW'(DEPTH));
  assign in_range  = (CMPW'(pos_r) < CMPW'(count_r));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (accept)    state_nxt = ST_SCAN;
      ST_SCAN:  if (last_scan) state_nxt = ST_APPLY;
      ST_APPLY: if (apply_go)  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // scan round counter
  assign cnt_nxt = (state_r == ST_SCAN) ? cnt_r + 1'b1 : '0;

  // sequencer outputs
  always_comb begin
    in_tready    = (state_r == ST_IDLE);
    ctl.val      = val_r;
    ctl.pos      = pos_r;
    ctl.load_tag = (state_r == ST_IDLE) && in_tvalid;
    ctl.swap_en  = (state_r == ST_SCAN) && (cmd_r == CMD_REVERSE);
    ctl.parity   = cnt_r[0];
    ctl.ins_en   = apply_go && (cmd_r == CMD_INSERT) && !full;
    ctl.rm_en    = apply_go && (cmd_r == CMD_REMOVE) && in_range;
  end

  // entry count
  always_comb begin
    count_nxt = count_r;
    if (ctl.ins_en) begin
      count_nxt = count_r + 1'b1;
    end else if (ctl.rm_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // result fields
  always_comb begin
    rd_value  = '0;
    rd_hit    = 1'b0;
    rd_status = STAT_OK;
    case (cmd_r)
      CMD_INSERT:   if (full) rd_status = STAT_FULL;
      CMD_CONTAINS: rd_hit = hit_w[0];
      CMD_GET: begin
        rd_hit   = in_range;
        rd_value = in_range ? get_w[0] : MISS_VALUE;
      end
      CMD_REMOVE:   if (!in_range) rd_status = STAT_RANGE;
      CMD_REVERSE:  rd_status = STAT_OK;
      default:      rd_status = STAT_OK;
    endcase
  end

  // hold the result until its transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (apply_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_tuser;
      val_r <= in_tdata[VAL_W-1:0];
      pos_r <= in_tdata[VAL_W+POS_W-1:VAL_W];
    end
    if (apply_go) begin
      out_data_r <= {OCC_W'(count_nxt), rd_status, rd_hit, rd_value};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VAL_W-1:0] lft_entry;
    logic                    lft_valid;
    logic [TW-1:0]           lft_tag;
    logic                    lft_pre;
    logic signed [VAL_W-1:0] rgt_entry;
    logic                    rgt_valid;
    logic [TW-1:0]           rgt_tag;
    logic signed [VAL_W-1:0] rgt_get;
    logic                    rgt_hit;

    if (i == 0) begin : g_head
      assign lft_entry = '0;
      assign lft_valid = 1'b0;
      assign lft_tag   = '0;
      assign lft_pre   = 1'b0;
    end else begin : g_left
      assign lft_entry = ent_w[i-1];
      assign lft_valid = vld_w[i-1];
      assign lft_tag   = tag_w[i-1];
      assign lft_pre   = pre_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign rgt_entry = '0;
      assign rgt_valid = 1'b0;
      assign rgt_tag   = '0;
      assign rgt_get   = '0;
      assign rgt_hit   = 1'b0;
    end else begin : g_right
      assign rgt_entry = ent_w[i+1];
      assign rgt_valid = vld_w[i+1];
      assign rgt_tag   = tag_w[i+1];
      assign rgt_get   = get_w[i+1];
      assign rgt_hit   = hit_w[i+1];
    end

    slt_cell #(
      .DEPTH (DEPTH),
      .IDX   (i)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .lft_entry (lft_entry),
      .lft_valid (lft_valid),
      .lft_tag   (lft_tag),
      .lft_pre   (lft_pre),
      .rgt_entry (rgt_entry),
      .rgt_valid (rgt_valid),
      .rgt_tag   (rgt_tag),
      .rgt_get   (rgt_get),
      .rgt_hit   (rgt_hit),
      .entry_o   (ent_w[i]),
      .valid_o   (vld_w[i]),
      .tag_o     (tag_w[i]),
      .pre_o     (pre_w[i]),
      .get_o     (get_w[i]),
      .hit_o     (hit_w[i])
    );

    assign vld_vec[i] = vld_w[i];
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count beyond depth");

  a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(vld_vec) == int'(count_r))
    else $error("valid cells disagree with entry count");

  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_SCAN) && (cnt_r == '0))
    else $error("accepted command did not start a scan");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_APPLY)
    else $error("result raised outside the apply step");

endmodule
